### rtl/core/lrcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrcf_pkg;

	// Fixed field widths
	localparam int LED_W    = 6;
	localparam int CH_W     = 8;
	localparam int RGB_W    = 24;
	localparam int FACTOR_W = 9;
	localparam int BRIGHT_W = 9;
	localparam int SCALE_W  = FACTOR_W + BRIGHT_W;
	localparam int CFG_IDX_W = 3;

	// Full blend weight, 1.0 in Q1.8
	localparam logic [FACTOR_W-1:0] FULL_FACTOR = 9'd256;
	localparam logic [FACTOR_W-1:0] HALF_FACTOR = 9'd128;
	localparam logic [CH_W-1:0]     CH_MAX      = 8'hFF;

	// Register reset values
	localparam logic [RGB_W-1:0] SECOND_COLOR_RST = 24'hFF0000;
	localparam logic [RGB_W-1:0] MINUTE_COLOR_RST = 24'h00FF00;
	localparam logic [RGB_W-1:0] HOUR_COLOR_RST   = 24'h0000FF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROTATION     = 3'd0,
		REG_SECOND_START = 3'd1,
		REG_MINUTE_START = 3'd2,
		REG_HOUR_START   = 3'd3,
		REG_SECOND_COLOR = 3'd4,
		REG_MINUTE_COLOR = 3'd5,
		REG_HOUR_COLOR   = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_BL_RD,
		ST_BL_MUL,
		ST_BL_WR,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [3:0]       rotation_offset;
		logic [LED_W-1:0] second_hand_start;
		logic [LED_W-1:0] minute_hand_start;
		logic [LED_W-1:0] hour_hand_start;
		logic [RGB_W-1:0] second_color;
		logic [RGB_W-1:0] minute_color;
		logic [RGB_W-1:0] hour_color;
	} cfg_t;

	typedef struct packed {
		logic [3:0]          hours;
		logic [5:0]          minutes;
		logic [5:0]          seconds;
		logic [7:0]          second_fraction;
		logic [BRIGHT_W-1:0] brightness;
	} item_t;

	typedef struct packed {
		logic [LED_W-1:0]    self_pos;
		logic [LED_W-1:0]    min_first;
		logic [LED_W-1:0]    hour_first;
		logic [2:0]          min_extra;
		logic [1:0]          hour_extra;
		logic [FACTOR_W-1:0] w_before;
		logic [FACTOR_W-1:0] w_self;
		logic [FACTOR_W-1:0] w_after;
	} place_t;

	typedef struct packed {
		logic [FACTOR_W-1:0] factor;
		logic [BRIGHT_W-1:0] bright;
		logic [RGB_W-1:0]    color;
	} blend_op_t;

endpackage

`default_nettype wire

### rtl/core/lrcf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lrcf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 60
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/core/lrcf_place.sv
`timescale 1ns / 1ps
`default_nettype none

module lrcf_place import lrcf_pkg::*; #(
	parameter int LED_COUNT     = 60,
	parameter int HOUR_STRIDE   = 5,
	parameter int MINUTE_STRIDE = 5
) (
	input  wire logic   clk,
	input  wire cfg_t   cfg,
	input  wire item_t  item,
	output place_t      place
);

	// Reduce a small value modulo the ring size by shifted compare and subtract
	function automatic logic [LED_W-1:0] mod_led(input logic [7:0] x);
		logic [9:0] r;
		r = {2'b00, x};
		for (int k = 3; k >= 0; k--) begin
			if (r >= (10'(LED_COUNT) << k)) begin
				r = r - (10'(LED_COUNT) << k);
			end
		end
		return r[LED_W-1:0];
	endfunction

	// Reduce a value below 48 modulo twelve
	function automatic logic [3:0] mod12(input logic [5:0] x);
		logic [5:0] r;
		r = x;
		if (r >= 6'd24) begin
			r = r - 6'd24;
		end
		if (r >= 6'd12) begin
			r = r - 6'd12;
		end
		return r[3:0];
	endfunction

	logic [LED_W-1:0]    rot_shift_s1;
	logic [LED_W-1:0]    sec_start_s1;
	logic [LED_W-1:0]    sec_s1;
	logic [3:0]          min_pos_s1;
	logic [3:0]          hour_pos_s1;
	logic                half_s1;
	logic [2:0]          min_extra_s1;
	logic [1:0]          hour_extra_s1;
	logic [FACTOR_W-1:0] wb_s1;
	logic [FACTOR_W-1:0] ws_s1;
	logic [FACTOR_W-1:0] wa_s1;
	logic [LED_W-1:0]    self_s2;
	logic [LED_W-1:0]    min_first_s2;
	logic [LED_W-1:0]    hour_first_s2;

	logic [13:0]         min_prod;
	logic [3:0]          min_quot;
	logic [5:0]          min_rem;
	logic [FACTOR_W-1:0] frac;
	logic [FACTOR_W-1:0] wb_d;
	logic [FACTOR_W-1:0] ws_d;
	logic [FACTOR_W-1:0] wa_d;
	logic [1:0]          hour_extra_d;
	logic [7:0]          self_sum;
	logic [7:0]          min_sum;
	logic [7:0]          hour_sum;

	// Minutes divided by five through a reciprocal, remainder by back multiply
	always_comb begin
		min_prod = 14'(item.minutes) * 14'd205;
		min_quot = min_prod[13:10];
		min_rem  = item.minutes - 6'(min_quot * 4'd5);
	end

	// Seconds hand cross-fade weights
	always_comb begin
		frac = {1'b0, item.second_fraction};
		wb_d = '0;
		wa_d = '0;
		priority if (frac < HALF_FACTOR) begin
			ws_d = frac + HALF_FACTOR;
			wb_d = HALF_FACTOR - frac;
		end else if (frac > HALF_FACTOR) begin
			ws_d = 9'd384 - frac;
			wa_d = frac - HALF_FACTOR;
		end else begin
			ws_d = FULL_FACTOR;
		end
	end

	// Hour highlight from ten-minute thresholds
	always_comb begin
		priority if (item.minutes < 6'd10) begin
			hour_extra_d = 2'd0;
		end else if (item.minutes < 6'd20) begin
			hour_extra_d = 2'd1;
		end else if (item.minutes < 6'd30) begin
			hour_extra_d = 2'd2;
		end else if (item.minutes < 6'd40) begin
			hour_extra_d = 2'd0;
		end else if (item.minutes < 6'd50) begin
			hour_extra_d = 2'd1;
		end else begin
			hour_extra_d = 2'd2;
		end
	end

	// First stage: dial positions with the rotation removed
	always_ff @(posedge clk) begin
		rot_shift_s1  <= mod_led(8'(cfg.rotation_offset) * 8'(HOUR_STRIDE));
		sec_start_s1  <= mod_led(8'(cfg.second_hand_start));
		sec_s1        <= mod_led(8'(item.seconds));
		min_pos_s1    <= mod12(6'(min_quot) + 6'd24 - 6'(cfg.rotation_offset));
		hour_pos_s1   <= mod12(6'(item.hours) + 6'd24 - 6'(cfg.rotation_offset));
		half_s1       <= (item.minutes >= 6'd30);
		min_extra_s1  <= min_rem[2:0];
		hour_extra_s1 <= hour_extra_d;
		wb_s1         <= wb_d;
		ws_s1         <= ws_d;
		wa_s1         <= wa_d;
	end

	// Second stage: LED indexes on the ring
	always_comb begin
		self_sum = 8'(sec_start_s1) + 8'(sec_s1) + 8'(LED_COUNT) - 8'(rot_shift_s1);
		min_sum  = 8'(cfg.minute_hand_start) + 8'(min_pos_s1) * 8'(MINUTE_STRIDE);
		hour_sum = 8'(cfg.hour_hand_start) + 8'(hour_pos_s1) * 8'(HOUR_STRIDE)
			+ (half_s1 ? 8'(HOUR_STRIDE) : 8'd0);
	end

	always_ff @(posedge clk) begin
		self_s2       <= mod_led(self_sum);
		min_first_s2  <= mod_led(min_sum);
		hour_first_s2 <= mod_led(hour_sum);
	end

	assign place.self_pos   = self_s2;
	assign place.min_first  = min_first_s2;
	assign place.hour_first = hour_first_s2;
	assign place.min_extra  = min_extra_s1;
	assign place.hour_extra = hour_extra_s1;
	assign place.w_before   = wb_s1;
	assign place.w_self     = ws_s1;
	assign place.w_after    = wa_s1;

endmodule

`default_nettype wire

### rtl/core/lrcf_blend.sv
`timescale 1ns / 1ps
`default_nettype none

module lrcf_blend import lrcf_pkg::*; (
	input  wire logic             clk,
	input  wire blend_op_t        op,
	input  wire logic [RGB_W-1:0] old_pixel,
	output logic      [RGB_W-1:0] new_pixel
);

	localparam int PROD_W = CH_W + SCALE_W;
	localparam int ADD_W  = PROD_W - 16 + 1;
	localparam int SUM_W  = ADD_W + 1;

	logic [SCALE_W-1:0] scale_s1;
	logic [RGB_W-1:0]   color_s1;
	logic [ADD_W-1:0]   add_s2 [3];
	logic [RGB_W-1:0]   old_s2;
	logic [ADD_W-1:0]   add_d  [3];
	logic [PROD_W-1:0]  prod   [3];
	logic [SUM_W-1:0]   sum    [3];

	// Scale is weight times brightness, Q.16
	always_ff @(posedge clk) begin
		scale_s1 <= SCALE_W'(op.factor) * SCALE_W'(op.bright);
		color_s1 <= op.color;
	end

	// Scale each channel and round up by one when both sides are nonzero
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			prod[ch]  = PROD_W'(color_s1[ch*CH_W +: CH_W]) * PROD_W'(scale_s1);
			add_d[ch] = ADD_W'(prod[ch][PROD_W-1:16])
				+ ADD_W'((color_s1[ch*CH_W +: CH_W] != '0) && (scale_s1 != '0));
		end
	end

	always_ff @(posedge clk) begin
		add_s2 <= add_d;
		old_s2 <= old_pixel;
	end

	// Add to the stored pixel and saturate
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum[ch] = SUM_W'(old_s2[ch*CH_W +: CH_W]) + SUM_W'(add_s2[ch]);
			new_pixel[ch*CH_W +: CH_W] = (sum[ch] > SUM_W'(CH_MAX)) ? CH_MAX
				: sum[ch][CH_W-1:0];
		end
	end

endmodule

`default_nettype wire

### rtl/core/led_ring_clock_face_render.sv
`timescale 1ns / 1ps
`default_nettype none

// LED ring clock face renderer.
// Command channel: drive the time sample on hours, minutes, seconds,
// second_fraction and brightness with start high; the sample is taken at a
// clock edge where start is high and busy is low. busy then stays high until
// the last LED word has been sent.
// Result channel: one word per LED in index order, LED 0 first, each on the
// result ports for one cycle with strobe high; last_led marks the final LED.
// The receiver cannot stall, so the sequence always runs at full pace.
// Per sample: the frame store (one single-port-write memory) is cleared one
// entry a cycle; each of the 5 + MINUTE_HAND_LEDS + HOUR_HAND_LEDS blends is
// a read, multiply, write pass through that memory; emitting then reads one
// entry a cycle.
// Configuration: cfg_ready is always high; write registers only while busy
// is low. Reset clears the sequencer and loads the register defaults.

module led_ring_clock_face_render import lrcf_pkg::*; #(
	parameter int LED_COUNT        = 60,
	parameter int HOUR_STRIDE      = 5,
	parameter int MINUTE_STRIDE    = 5,
	parameter int MINUTE_HAND_LEDS = 5,
	parameter int HOUR_HAND_LEDS   = 3
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [3:0]           hours,
	input  wire logic [5:0]           minutes,
	input  wire logic [5:0]           seconds,
	input  wire logic [7:0]           second_fraction,
	input  wire logic [BRIGHT_W-1:0]  brightness,
	output logic                      strobe,
	output logic [LED_W-1:0]          led_index,
	output logic [CH_W-1:0]           red,
	output logic [CH_W-1:0]           green,
	output logic [CH_W-1:0]           blue,
	output logic                      last_led,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [RGB_W-1:0]     cfg_data
);

	localparam int AW         = $clog2(LED_COUNT);
	localparam int NOPS       = 5 + MINUTE_HAND_LEDS + HOUR_HAND_LEDS;
	localparam int OPW        = $clog2(NOPS);
	localparam int MIN_BASE   = 3;
	localparam int MIN_EXTRA  = MIN_BASE + MINUTE_HAND_LEDS;
	localparam int HOUR_BASE  = MIN_EXTRA + 1;
	localparam int HOUR_EXTRA = HOUR_BASE + HOUR_HAND_LEDS;

	state_t state_q;
	state_t state_d;
	cfg_t   cfg_q;
	item_t  item_q;
	place_t place;

	logic [AW-1:0]    cnt_q;
	logic [OPW-1:0]   op_q;
	logic             cnt_last;
	logic             op_last;
	logic             accept;
	logic             strobe_q;
	logic [AW-1:0]    led_s1;

	blend_op_t        op;
	logic [LED_W-1:0] op_base;
	logic [LED_W-1:0] op_offset;
	logic [LED_W:0]   op_sum;
	logic [LED_W-1:0] op_addr;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [RGB_W-1:0] mem_wdata;
	logic [AW-1:0]    mem_raddr;
	logic [RGB_W-1:0] mem_rdata;
	logic [RGB_W-1:0] new_pixel;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE) || strobe_q;
	assign cfg_ready = 1'b1;
	assign cnt_last  = (cnt_q == AW'(LED_COUNT - 1));
	assign op_last   = (op_q == OPW'(NOPS - 1));

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rotation_offset   <= '0;
			cfg_q.second_hand_start <= '0;
			cfg_q.minute_hand_start <= '0;
			cfg_q.hour_hand_start   <= '0;
			cfg_q.second_color      <= SECOND_COLOR_RST;
			cfg_q.minute_color      <= MINUTE_COLOR_RST;
			cfg_q.hour_color        <= HOUR_COLOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROTATION:     cfg_q.rotation_offset   <= cfg_data[3:0];
				REG_SECOND_START: cfg_q.second_hand_start <= cfg_data[LED_W-1:0];
				REG_MINUTE_START: cfg_q.minute_hand_start <= cfg_data[LED_W-1:0];
				REG_HOUR_START:   cfg_q.hour_hand_start   <= cfg_data[LED_W-1:0];
				REG_SECOND_COLOR: cfg_q.second_color      <= cfg_data;
				REG_MINUTE_COLOR: cfg_q.minute_color      <= cfg_data;
				REG_HOUR_COLOR:   cfg_q.hour_color        <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold the time sample for the whole frame
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.hours           <= hours;
			item_q.minutes         <= minutes;
			item_q.seconds         <= seconds;
			item_q.second_fraction <= second_fraction;
			item_q.brightness      <= brightness;
		end
	end

	lrcf_place #(
		.LED_COUNT    (LED_COUNT),
		.HOUR_STRIDE  (HOUR_STRIDE),
		.MINUTE_STRIDE(MINUTE_STRIDE)
	) u_place (
		.clk  (clk),
		.cfg  (cfg_q),
		.item (item_q),
		.place(place)
	);

	// Decode the current blend: target LED, weight and colour
	always_comb begin
		op.bright = item_q.brightness;
		priority if (op_q < OPW'(MIN_BASE)) begin
			op_base  = place.self_pos;
			op.color = cfg_q.second_color;
			priority if (op_q == OPW'(0)) begin
				op_offset = LED_W'(LED_COUNT - 1);
				op.factor = place.w_before;
			end else if (op_q == OPW'(1)) begin
				op_offset = '0;
				op.factor = place.w_self;
			end else begin
				op_offset = LED_W'(1);
				op.factor = place.w_after;
			end
		end else if (op_q < OPW'(MIN_EXTRA)) begin
			op_base   = place.min_first;
			op_offset = LED_W'(op_q - OPW'(MIN_BASE));
			op.factor = FULL_FACTOR;
			op.color  = cfg_q.minute_color;
		end else if (op_q == OPW'(MIN_EXTRA)) begin
			op_base   = place.min_first;
			op_offset = LED_W'(place.min_extra);
			op.factor = FULL_FACTOR;
			op.color  = cfg_q.minute_color;
		end else if (op_q < OPW'(HOUR_EXTRA)) begin
			op_base   = place.hour_first;
			op_offset = LED_W'(op_q - OPW'(HOUR_BASE));
			op.factor = FULL_FACTOR;
			op.color  = cfg_q.hour_color;
		end else begin
			op_base   = place.hour_first;
			op_offset = LED_W'(place.hour_extra);
			op.factor = FULL_FACTOR;
			op.color  = cfg_q.hour_color;
		end
		op_sum  = {1'b0, op_base} + {1'b0, op_offset};
		op_addr = (op_sum >= (LED_W + 1)'(LED_COUNT))
			? LED_W'(op_sum - (LED_W + 1)'(LED_COUNT)) : op_sum[LED_W-1:0];
	end

	lrcf_blend u_blend (
		.clk      (clk),
		.op       (op),
		.old_pixel(mem_rdata),
		.new_pixel(new_pixel)
	);

	lrcf_ram #(
		.WIDTH(RGB_W),
		.DEPTH(LED_COUNT)
	) u_frame (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) state_d = ST_CLEAR;
			ST_CLEAR:  if (cnt_last) state_d = ST_BL_RD;
			ST_BL_RD:  state_d = ST_BL_MUL;
			ST_BL_MUL: state_d = ST_BL_WR;
			ST_BL_WR:  state_d = op_last ? ST_EMIT : ST_BL_RD;
			ST_EMIT:   if (cnt_last) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Memory port control per state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = '0;
		mem_raddr = cnt_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_BL_RD: begin
				mem_raddr = op_addr[AW-1:0];
			end
			ST_BL_WR: begin
				mem_we    = 1'b1;
				mem_waddr = op_addr[AW-1:0];
				mem_wdata = new_pixel;
			end
			default: ;
		endcase
	end

	// Advance state, LED counter and blend counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			op_q     <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= (state_q == ST_EMIT);
			if (state_q == ST_CLEAR || state_q == ST_EMIT) begin
				cnt_q <= cnt_last ? '0 : cnt_q + AW'(1);
			end
			if (state_q == ST_BL_WR) begin
				op_q <= op_last ? '0 : op_q + OPW'(1);
			end
		end
	end

	// Track the LED whose word arrives from the memory next cycle
	always_ff @(posedge clk) begin
		led_s1 <= cnt_q;
	end

	assign strobe    = strobe_q;
	assign led_index = LED_W'(led_s1);
	assign red       = mem_rdata[2*CH_W +: CH_W];
	assign green     = mem_rdata[CH_W +: CH_W];
	assign blue      = mem_rdata[0 +: CH_W];
	assign last_led  = (led_s1 == AW'(LED_COUNT - 1));

endmodule

`default_nettype wire

### test/face_frame_checker.sv
`timescale 1ns / 1ps

// Watch the sample, result and register channels of the clock face renderer,
// paint each expected frame and compare every LED word as it goes by.
module face_frame_checker import lrcf_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 busy,
	input  wire logic [3:0]           hours,
	input  wire logic [5:0]           minutes,
	input  wire logic [5:0]           seconds,
	input  wire logic [7:0]           second_fraction,
	input  wire logic [BRIGHT_W-1:0]  brightness,
	input  wire logic                 strobe,
	input  wire logic [LED_W-1:0]     led_index,
	input  wire logic [CH_W-1:0]      red,
	input  wire logic [CH_W-1:0]      green,
	input  wire logic [CH_W-1:0]      blue,
	input  wire logic                 last_led,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [RGB_W-1:0]     cfg_data,
	output int                        miss_count,
	output int                        pending
);

	localparam int RING_LEDS   = 60;
	localparam int HOUR_STEP   = 5;
	localparam int MINUTE_STEP = 5;
	localparam int MINUTE_SPAN = 5;
	localparam int HOUR_SPAN   = 3;

	typedef struct {
		logic [LED_W-1:0] led;
		logic [CH_W-1:0]  r;
		logic [CH_W-1:0]  g;
		logic [CH_W-1:0]  b;
		logic             last;
	} led_word_t;

	cfg_t             face_cfg;
	logic [RGB_W-1:0] frame [RING_LEDS];
	led_word_t        words_due [$];
	led_word_t        due;
	bit               bad;

	// Add one scaled channel with round-up and clamp at full scale
	function automatic logic [CH_W-1:0] mix(logic [CH_W-1:0] old, logic [CH_W-1:0] c,
			int unsigned scale);
		int unsigned sum;
		sum = (32'(c) * scale) >> 16;
		if (c != 0 && scale != 0)
			sum++;
		sum += 32'(old);
		return (sum > 255) ? CH_MAX : sum[CH_W-1:0];
	endfunction

	// Blend a hand colour into one LED of the frame
	function automatic void paint(int unsigned led, int unsigned factor, logic [RGB_W-1:0] rgb,
			int unsigned bright);
		int unsigned      idx;
		int unsigned      scale;
		logic [RGB_W-1:0] old;
		idx = led % RING_LEDS;
		scale = factor * bright;
		old = frame[idx];
		frame[idx] = {mix(old[23:16], rgb[23:16], scale), mix(old[15:8], rgb[15:8], scale),
			mix(old[7:0], rgb[7:0], scale)};
	endfunction

	// Paint the whole face for one sample and queue its LED words
	function automatic void render_face(item_t s);
		int unsigned rot, frac, bright, mins, self_led, pos, first, extra;
		int unsigned w_before, w_self, w_after;
		led_word_t   w;
		rot = 32'(face_cfg.rotation_offset);
		frac = 32'(s.second_fraction);
		bright = 32'(s.brightness);
		mins = 32'(s.minutes);
		w_before = 0;
		w_after = 0;
		for (int i = 0; i < RING_LEDS; i++)
			frame[i] = '0;

		// seconds hand: cross-fade over the neighbours
		if (frac < 128) begin
			w_self = frac + 128;
			w_before = 128 - frac;
		end else if (frac > 128) begin
			w_self = 384 - frac;
			w_after = frac - 128;
		end else begin
			w_self = 256;
		end
		self_led = (32'(face_cfg.second_hand_start) + 32'(s.seconds) + RING_LEDS
			- (rot * HOUR_STEP) % RING_LEDS) % RING_LEDS;
		if (w_before != 0)
			paint(self_led + RING_LEDS - 1, w_before, face_cfg.second_color, bright);
		if (w_self != 0)
			paint(self_led, w_self, face_cfg.second_color, bright);
		if (w_after != 0)
			paint(self_led + 1, w_after, face_cfg.second_color, bright);

		// minute hand: segment plus highlight
		pos = (mins / 5 + 24 - rot) % 12;
		first = (32'(face_cfg.minute_hand_start) + pos * MINUTE_STEP) % RING_LEDS;
		for (int i = 0; i < MINUTE_SPAN; i++)
			paint(first + i, 32'(FULL_FACTOR), face_cfg.minute_color, bright);
		paint(first + mins % 5, 32'(FULL_FACTOR), face_cfg.minute_color, bright);

		// hour hand: half-hour segment plus highlight
		pos = (32'(s.hours) + 24 - rot) % 12;
		first = 32'(face_cfg.hour_hand_start) + pos * HOUR_STEP;
		if (mins >= 30)
			first += HOUR_STEP;
		first %= RING_LEDS;
		if (mins < 10)
			extra = 0;
		else if (mins < 20)
			extra = 1;
		else if (mins < 30)
			extra = 2;
		else if (mins < 40)
			extra = 0;
		else if (mins < 50)
			extra = 1;
		else
			extra = 2;
		for (int i = 0; i < HOUR_SPAN; i++)
			paint(first + i, 32'(FULL_FACTOR), face_cfg.hour_color, bright);
		paint(first + extra, 32'(FULL_FACTOR), face_cfg.hour_color, bright);

		// queue the frame in LED order
		for (int i = 0; i < RING_LEDS; i++) begin
			w.led = i[LED_W-1:0];
			w.r = frame[i][23:16];
			w.g = frame[i][15:8];
			w.b = frame[i][7:0];
			w.last = (i == RING_LEDS - 1);
			words_due.push_back(w);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_cfg.rotation_offset = '0;
			face_cfg.second_hand_start = '0;
			face_cfg.minute_hand_start = '0;
			face_cfg.hour_hand_start = '0;
			face_cfg.second_color = SECOND_COLOR_RST;
			face_cfg.minute_color = MINUTE_COLOR_RST;
			face_cfg.hour_color = HOUR_COLOR_RST;
			words_due.delete();
			miss_count = 0;
		end else begin
			// take register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ROTATION:     face_cfg.rotation_offset = cfg_data[3:0];
					REG_SECOND_START: face_cfg.second_hand_start = cfg_data[LED_W-1:0];
					REG_MINUTE_START: face_cfg.minute_hand_start = cfg_data[LED_W-1:0];
					REG_HOUR_START:   face_cfg.hour_hand_start = cfg_data[LED_W-1:0];
					REG_SECOND_COLOR: face_cfg.second_color = cfg_data;
					REG_MINUTE_COLOR: face_cfg.minute_color = cfg_data;
					REG_HOUR_COLOR:   face_cfg.hour_color = cfg_data;
					default:          ;
				endcase
			end

			// predict a frame for each accepted sample
			if (start && !busy)
				render_face({hours, minutes, seconds, second_fraction, brightness});

			// compare each LED word with the oldest expectation
			if (strobe) begin
				if (words_due.size() == 0) begin
					$error("LED word %0d arrived with no frame pending", led_index);
					miss_count++;
				end else begin
					due = words_due.pop_front();
					bad = 0;
					if (led_index !== due.led) begin
						$error("led_index: expected %0d, got %0d", due.led, led_index);
						bad = 1;
					end
					if (red !== due.r) begin
						$error("red: expected %0d, got %0d", due.r, red);
						bad = 1;
					end
					if (green !== due.g) begin
						$error("green: expected %0d, got %0d", due.g, green);
						bad = 1;
					end
					if (blue !== due.b) begin
						$error("blue: expected %0d, got %0d", due.b, blue);
						bad = 1;
					end
					if (last_led !== due.last) begin
						$error("last_led: expected %0d, got %0d", due.last, last_led);
						bad = 1;
					end
					if (bad)
						miss_count++;
				end
			end
		end
		pending = words_due.size();
	end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
	import lrcf_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [3:0]           hours = '0;
	logic [5:0]           minutes = '0;
	logic [5:0]           seconds = '0;
	logic [7:0]           second_fraction = '0;
	logic [BRIGHT_W-1:0]  brightness = '0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [RGB_W-1:0]     cfg_data = '0;
	logic                 busy;
	logic                 strobe;
	logic [LED_W-1:0]     led_index;
	logic [CH_W-1:0]      red;
	logic [CH_W-1:0]      green;
	logic [CH_W-1:0]      blue;
	logic                 last_led;
	logic                 cfg_ready;
	int                   miss_count;
	int                   pending;
	int                   quiet_cycles = 0;
	int                   samples_sent = 0;
	int                   settings_used = 0;
	int                   words_seen = 0;
	bit                   idle_on = 1'b1;

	always #4 clk = ~clk;

	led_ring_clock_face_render dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.hours           (hours),
		.minutes         (minutes),
		.seconds         (seconds),
		.second_fraction (second_fraction),
		.brightness      (brightness),
		.strobe          (strobe),
		.led_index       (led_index),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.last_led        (last_led),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	face_frame_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.hours           (hours),
		.minutes         (minutes),
		.seconds         (seconds),
		.second_fraction (second_fraction),
		.brightness      (brightness),
		.strobe          (strobe),
		.led_index       (led_index),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.last_led        (last_led),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.miss_count      (miss_count),
		.pending         (pending)
	);

	// Drop the run when nothing moves for too long
	always @(posedge clk) begin
		if (strobe)
			words_seen <= words_seen + 1;
		if (!arst_n || (start && !busy) || strobe || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Offer one time sample and hold it until the block takes it
	task automatic send_sample(logic [3:0] h, logic [5:0] m, logic [5:0] s, logic [7:0] f,
			logic [BRIGHT_W-1:0] b);
		int gap;
		if (idle_on && $urandom_range(99) < 34) begin
			gap = ($urandom_range(3) == 0) ? $urandom_range(20, 180) : $urandom_range(1, 12);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		hours <= h;
		minutes <= m;
		seconds <= s;
		second_fraction <= f;
		brightness <= b;
		do @(posedge clk); while (busy);
		samples_sent++;
	endtask

	// Write one register word
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RGB_W-1:0] data);
		if (idle_on && $urandom_range(99) < 34) begin
			cfg_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Stop offering samples and wait for the last frame to drain
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (busy || pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Load every register; narrow ones get junk in their unused bits
	task automatic load_face(logic [3:0] rot, logic [5:0] sec0, logic [5:0] min0,
			logic [5:0] hr0, logic [RGB_W-1:0] sec_rgb, logic [RGB_W-1:0] min_rgb,
			logic [RGB_W-1:0] hr_rgb);
		logic [RGB_W-1:0] noise;
		noise = 24'($urandom());
		write_reg(REG_ROTATION, {noise[23:4], rot});
		write_reg(REG_SECOND_START, {noise[23:6], sec0});
		write_reg(REG_MINUTE_START, {noise[17:0], min0});
		write_reg(REG_UNUSED, noise);
		write_reg(REG_HOUR_START, {noise[20:3], hr0});
		write_reg(REG_SECOND_COLOR, sec_rgb);
		write_reg(REG_MINUTE_COLOR, min_rgb);
		write_reg(REG_HOUR_COLOR, hr_rgb);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Mostly dial-valid times, some with every field bit free
	task automatic run_random(int count);
		logic [3:0]          h;
		logic [5:0]          m;
		logic [5:0]          s;
		logic [7:0]          f;
		logic [BRIGHT_W-1:0] b;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 15) begin
				h = 4'($urandom_range(15));
				m = 6'($urandom_range(63));
				s = 6'($urandom_range(63));
				b = 9'($urandom_range(511));
			end else begin
				h = 4'($urandom_range(11));
				m = 6'($urandom_range(59));
				s = 6'($urandom_range(59));
				b = ($urandom_range(4) == 0) ? 9'd256 : 9'($urandom_range(256));
			end
			f = ($urandom_range(9) == 0) ? 8'd128 : 8'($urandom_range(255));
			send_sample(h, m, s, f, b);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed samples on the reset colours: fraction edges, hour highlight
		// thresholds, zero and overdriven brightness, out-of-dial times
		send_sample(4'd0, 6'd0, 6'd0, 8'd0, 9'd256);
		send_sample(4'd11, 6'd59, 6'd59, 8'd255, 9'd256);
		send_sample(4'd15, 6'd63, 6'd63, 8'd128, 9'd511);
		send_sample(4'd0, 6'd9, 6'd1, 8'd127, 9'd1);
		send_sample(4'd1, 6'd10, 6'd2, 8'd129, 9'd0);
		send_sample(4'd2, 6'd19, 6'd3, 8'd1, 9'd256);
		send_sample(4'd3, 6'd20, 6'd4, 8'd128, 9'd256);
		send_sample(4'd4, 6'd29, 6'd5, 8'd64, 9'd100);
		send_sample(4'd5, 6'd30, 6'd6, 8'd200, 9'd300);
		send_sample(4'd6, 6'd39, 6'd30, 8'd0, 9'd511);
		send_sample(4'd7, 6'd40, 6'd31, 8'd255, 9'd511);
		send_sample(4'd8, 6'd49, 6'd58, 8'd128, 9'd1);
		send_sample(4'd9, 6'd50, 6'd59, 8'd127, 9'd256);
		send_sample(4'd10, 6'd55, 6'd0, 8'd129, 9'd256);
		send_sample(4'd11, 6'd0, 6'd12, 8'd0, 9'd256);
		send_sample(4'd12, 6'd60, 6'd60, 8'd200, 9'd257);
		send_sample(4'd13, 6'd14, 6'd45, 8'd55, 9'd128);
		send_sample(4'd14, 6'd35, 6'd15, 8'd150, 9'd384);

		// register extremes, then random settings
		settle();
		load_face(4'd0, 6'd0, 6'd0, 6'd0, 24'h000000, 24'h000000, 24'h000000);
		run_random(40);
		settle();
		load_face(4'd15, 6'd63, 6'd63, 6'd63, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		run_random(60);
		settle();
		load_face(4'd11, 6'd59, 6'd59, 6'd59, 24'($urandom()), 24'($urandom()),
			24'($urandom()));
		run_random(60);
		settle();
		load_face(4'd0, 6'd0, 6'd0, 6'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		run_random(40);
		for (int p = 0; p < 5; p++) begin
			settle();
			idle_on = (p != 2);
			load_face(4'($urandom_range(15)), 6'($urandom_range(63)), 6'($urandom_range(63)),
				6'($urandom_range(63)), 24'($urandom()), 24'($urandom()), 24'($urandom()));
			run_random(52);
		end
		idle_on = 1'b1;

		// drain the last frame
		settle();
		repeat (8) @(posedge clk);

		$display("Rendered %0d time samples under %0d register settings plus reset values,",
			samples_sent, settings_used);
		$display("comparing %0d LED words field by field.", words_seen);
		if (miss_count == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
